/* design/sgra_pkg.sv */
`timescale 1ns / 1ps
// Shared opcodes and controller/datapath interface types for the sparse row store.
package sgra_pkg;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_ROW  = 2'd1;
	localparam logic [1:0] OP_WGT  = 2'd2;
	localparam logic [1:0] OP_NOP  = 2'd3;

	localparam logic [4:0] WGT_MAX = 5'd31;

	typedef struct packed {
		logic clr_wr;
		logic cap;
		logic load;
		logic el_rd_merge;
		logic el_rd_pos;
		logic emit_old;
		logic emit_new;
		logic match;
		logic commit;
		logic wt_rd;
		logic wt_wr;
		logic res;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       last;
		logic       act_item;
		logic       dcmp;
		logic       have_old;
		logic       old_lt;
		logic       old_eq;
		logic       full;
		logic       col_ok;
		logic       old_ok;
		logic       rd_ok;
		logic       clr_last;
	} stat_t;

endpackage

/* design/sgra_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for clearing, merge steps, weight updates and reads.
module sgra_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sgra_pkg::stat_t st,
	output sgra_pkg::cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_CLR  = 11'b00000000001,
		S_IDLE = 11'b00000000010,
		S_LOAD = 11'b00000000100,
		S_INFO = 11'b00000001000,
		S_ERD  = 11'b00000010000,
		S_EVAL = 11'b00000100000,
		S_ORD  = 11'b00001000000,
		S_OCMP = 11'b00010000000,
		S_WRD  = 11'b00100000000,
		S_WWR  = 11'b01000000000,
		S_NEXT = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		logic need;
		need    = 1'b0;
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_INFO;
			end
			S_INFO: begin
				if (st.op == sgra_pkg::OP_ADD && st.act_item) begin
					state_d = S_ORD;
				end else if (st.op == sgra_pkg::OP_ROW && st.rd_ok) begin
					state_d = S_ERD;
				end else begin
					cmd.res = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ERD: begin
				cmd.el_rd_pos = 1'b1;
				state_d       = S_EVAL;
			end
			S_EVAL: begin
				cmd.res = 1'b1;
				state_d = S_IDLE;
			end
			S_ORD: begin
				cmd.el_rd_merge = 1'b1;
				state_d         = S_OCMP;
			end
			S_OCMP: begin
				state_d = S_NEXT;
				if (!st.dcmp) begin
					if (st.have_old && st.old_lt) begin
						cmd.emit_old = 1'b1;
						need         = st.full && st.old_ok;
					end else if (st.have_old && st.old_eq) begin
						cmd.match = 1'b1;
						need      = st.col_ok;
					end else begin
						cmd.emit_new = 1'b1;
						need         = !st.full && st.col_ok;
					end
				end else if (st.have_old) begin
					// tail copy after the last beat
					cmd.emit_old = 1'b1;
					need         = st.full && st.old_ok;
				end else begin
					cmd.commit = 1'b1;
					cmd.res    = 1'b1;
					state_d    = S_IDLE;
				end
				if (need) state_d = S_WRD;
			end
			S_WRD: begin
				cmd.wt_rd = 1'b1;
				state_d   = S_WWR;
			end
			S_WWR: begin
				cmd.wt_wr = 1'b1;
				state_d   = S_NEXT;
			end
			S_NEXT: begin
				if (st.dcmp && !st.last) begin
					cmd.res = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_ORD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/sgra_dpath.sv */
`timescale 1ns / 1ps
// Row element, row info and column weight stores with merge registers.
module sgra_dpath #(
	parameter int ROWS    = 16,
	parameter int MAX_LEN = 64,
	parameter int COLS    = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      opcode,
	input  logic [3:0]      row_index,
	input  logic [15:0]     column,
	input  logic [5:0]      position,
	input  logic            last,
	input  sgra_pkg::cmd_t  cmd,
	output sgra_pkg::stat_t st,
	output logic            done,
	output logic [6:0]      row_length,
	output logic [15:0]     read_value,
	output logic            overflow
);

	localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LW     = $clog2(MAX_LEN + 1);
	localparam int EDEPTH = 2 * ROWS * MAX_LEN;
	localparam int EAW    = $clog2(EDEPTH);
	localparam int CAW    = $clog2(COLS);
	localparam int CLR_N  = (COLS > ROWS) ? COLS : ROWS;
	localparam int CLRW   = $clog2(CLR_N);

	logic [15:0]   emem [EDEPTH];
	logic [LW:0]   rmem [ROWS];
	logic [4:0]    wmem [COLS];

	logic [1:0]    op_q;
	logic [3:0]    r_q;
	logic [15:0]   col_q;
	logic [5:0]    pos_q;
	logic          last_q;

	logic [LW:0]   info_q;
	logic [15:0]   elem_q;
	logic [4:0]    wrd_q;
	logic [CAW-1:0] w_addr_q;
	logic          w_dec_q;

	logic          active_q, act_item_q, movf_q, dcmp_q;
	logic [RW-1:0] mrow_q;
	logic [LW-1:0] rpos_q, wpos_q;
	logic [CLRW-1:0] clr_q;

	logic [LW-1:0] info_len;
	logic          info_bank, nbank;
	logic          r_ok, col_ok, full, have_old;
	logic [RW-1:0] ia;
	logic [LW-1:0] rsel;
	logic [EAW-1:0] ea_w, ea_m, ea_p;
	logic [4:0]    wnew;

	assign info_len  = info_q[LW:1];
	assign info_bank = info_q[0];
	assign nbank     = ~info_bank;
	assign r_ok      = 32'(r_q) < ROWS;
	assign col_ok    = 32'(col_q) < COLS;
	assign full      = wpos_q >= LW'(MAX_LEN);
	assign have_old  = rpos_q < info_len;
	assign ia        = (op_q == sgra_pkg::OP_ADD && active_q) ? mrow_q : RW'(r_q);
	assign rsel      = have_old ? rpos_q : '0;

	assign ea_w = EAW'((32'(mrow_q) * 2 + 32'(nbank)) * MAX_LEN + 32'(wpos_q));
	assign ea_m = EAW'((32'(mrow_q) * 2 + 32'(info_bank)) * MAX_LEN + 32'(rsel));
	assign ea_p = EAW'((32'(RW'(r_q)) * 2 + 32'(info_bank)) * MAX_LEN + 32'(pos_q));

	assign wnew = w_dec_q ? ((wrd_q == 5'd0) ? 5'd0 : wrd_q - 5'd1)
	                      : ((wrd_q == sgra_pkg::WGT_MAX) ? wrd_q : wrd_q + 5'd1);

	always_comb begin
		st          = '0;
		st.op       = op_q;
		st.last     = last_q;
		st.act_item = act_item_q;
		st.dcmp     = dcmp_q;
		st.have_old = have_old;
		st.old_lt   = elem_q < col_q;
		st.old_eq   = elem_q == col_q;
		st.full     = full;
		st.col_ok   = col_ok;
		st.old_ok   = 32'(elem_q) < COLS;
		st.rd_ok    = r_ok && (32'(pos_q) < 32'(info_len)) && (32'(pos_q) < MAX_LEN);
		st.clr_last = clr_q == CLRW'(CLR_N - 1);
	end

	// memories: registered reads, single write port each
	always_ff @(posedge clk) begin
		if (cmd.clr_wr && 32'(clr_q) < ROWS) rmem[clr_q[RW-1:0]] <= '0;
		if (cmd.commit) rmem[mrow_q] <= {wpos_q, nbank};
		if (cmd.load) info_q <= rmem[ia];
	end

	always_ff @(posedge clk) begin
		if ((cmd.emit_old || cmd.emit_new) && !full)
			emem[ea_w] <= cmd.emit_old ? elem_q : col_q;
		if (cmd.el_rd_merge) elem_q <= emem[ea_m];
		else if (cmd.el_rd_pos) elem_q <= emem[ea_p];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr && 32'(clr_q) < COLS) wmem[clr_q[CAW-1:0]] <= '0;
		if (cmd.wt_wr) wmem[w_addr_q] <= wnew;
		if (cmd.load) wrd_q <= wmem[CAW'(col_q)];
		else if (cmd.wt_rd) wrd_q <= wmem[w_addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= opcode;
			r_q    <= row_index;
			col_q  <= column;
			pos_q  <= position;
			last_q <= last;
		end
		if (cmd.emit_old) begin
			w_addr_q <= CAW'(elem_q);
			w_dec_q  <= 1'b1;
		end else if (cmd.match || cmd.emit_new) begin
			w_addr_q <= CAW'(col_q);
			w_dec_q  <= cmd.match;
		end
		if (cmd.res) begin
			if (op_q == sgra_pkg::OP_ADD) begin
				row_length <= act_item_q ? 7'(wpos_q) : 7'd0;
				read_value <= '0;
				overflow   <= act_item_q && movf_q;
			end else begin
				row_length <= r_ok ? 7'(info_len) : 7'd0;
				overflow   <= 1'b0;
				if (op_q == sgra_pkg::OP_ROW && st.rd_ok)
					read_value <= elem_q;
				else if (op_q == sgra_pkg::OP_WGT && r_ok && col_ok)
					read_value <= 16'(wrd_q);
				else
					read_value <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			act_item_q <= 1'b0;
			movf_q     <= 1'b0;
			dcmp_q     <= 1'b0;
			mrow_q     <= '0;
			rpos_q     <= '0;
			wpos_q     <= '0;
			clr_q      <= '0;
			done       <= 1'b0;
		end else begin
			done <= cmd.res;
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				dcmp_q     <= 1'b0;
				act_item_q <= (op_q == sgra_pkg::OP_ADD) && (active_q || r_ok);
				if (op_q == sgra_pkg::OP_ADD && !active_q && r_ok) begin
					active_q <= 1'b1;
					mrow_q   <= RW'(r_q);
					rpos_q   <= '0;
					wpos_q   <= '0;
					movf_q   <= 1'b0;
				end
			end
			if (cmd.emit_old || cmd.emit_new) begin
				if (full) movf_q <= 1'b1;
				else      wpos_q <= wpos_q + 1'b1;
			end
			if (cmd.emit_old || cmd.match) rpos_q <= rpos_q + 1'b1;
			if (cmd.emit_new || cmd.match) dcmp_q <= 1'b1;
			if (cmd.commit) active_q <= 1'b0;
		end
	end

endmodule

/* design/sparse_gf2_row_add_with_weights.sv */
`timescale 1ns / 1ps
// Sparse GF(2) row store: merges relations into rows, keeps per-column weights.
//
// Usage: drive opcode/row_index/column/position/last and raise start; the beat
// is taken on a clock edge with start high and busy low. Each beat gives one
// result on row_length/read_value/overflow, marked by done for one cycle.
// The receiver has no way to hold a result off; it must take it that cycle.
// Reads (row element, column weight) fetch the row info, and a row element
// read then fetches the element before done. A relation element steps past
// each older row entry that sorts below it, and each weight update goes
// through the shared read-modify-write port of the weight store; the last
// element also copies the remaining old entries and then commits the row by
// flipping its bank.
// Results are registered, so the next beat can be taken while done is high.
// After reset the weight store and row info are swept to zero, one address
// per cycle over max(COLS, ROWS) addresses; busy stays high during the sweep.
module sparse_gf2_row_add_with_weights #(
	parameter int ROWS    = 16,
	parameter int MAX_LEN = 64,
	parameter int COLS    = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [3:0]  row_index,
	input  logic [15:0] column,
	input  logic [5:0]  position,
	input  logic        last,
	output logic        done,
	output logic [6:0]  row_length,
	output logic [15:0] read_value,
	output logic        overflow
);

	sgra_pkg::cmd_t  cmd;
	sgra_pkg::stat_t st;

	sgra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	sgra_dpath #(
		.ROWS    (ROWS),
		.MAX_LEN (MAX_LEN),
		.COLS    (COLS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.row_index  (row_index),
		.column     (column),
		.position   (position),
		.last       (last),
		.cmd        (cmd),
		.st         (st),
		.done       (done),
		.row_length (row_length),
		.read_value (read_value),
		.overflow   (overflow)
	);

endmodule

/* design/sgra_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the sparse row store, bound to the top level.
module sgra_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// a result is only shown once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after accept");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");

endmodule

bind sparse_gf2_row_add_with_weights sgra_checker u_sgra_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
